// ----- rtl/slri_pkg.sv -----
// Shared types and constants for the sorted list insert/remove block.
package slri_pkg;

  // Width of one stored value
  localparam int DATA_W = 32;

  // Width of the transaction's count field
  localparam int COUNT_W = 5;

  // Operation codes carried by an input transaction
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVENS  = 2'd2
  } op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_RD,
    ST_REM_CMP,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_EVN_RD,
    ST_EVN_CHK,
    ST_LG_RD,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/slri_mem.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
module slri_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [slri_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [slri_pkg::DATA_W-1:0] rdata
);
  import slri_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sorted_list_insert_remove.sv -----
// Top level of the sorted list insert/remove block.
// Keeps up to DEPTH signed 32-bit values in ascending order in a single memory
// with one write port and one registered read port, walked by a small
// sequencer around one shared compare unit. One transaction is taken at a
// time; in_stall stays high from acceptance until the result is loaded into
// the output register. Each entry visited takes a read state, then a compare
// and write state. Insert visits the entries larger than the value; remove
// visits the entries up to the match, then moves each later entry down one
// slot (every entry is visited when the value is absent); remove-evens visits
// every entry; an unused op code or a full-list insert visits none. The
// longest operation is a remove or remove-evens on a full list. Once the
// result is loaded, the next transaction can be taken while that result
// still waits in the output register.
// The memory needs no clearing pass: only entries below the count are ever
// read.
module sorted_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic signed [slri_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_ok,
  output logic [slri_pkg::COUNT_W-1:0]       out_count,
  output logic signed [slri_pkg::DATA_W-1:0] out_largest,
  output logic                               out_is_empty,
  output logic                               out_is_full
);
  import slri_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t            state_r, state_nxt;
  logic [1:0]        op_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     w_r, w_nxt;
  logic              ok_r, ok_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              cmp_gt, cmp_eq;
  logic              full;
  logic              accept;
  logic              load_out;
  logic [CW-1:0]     k_dec, k_inc, w_inc, cnt_dec;
  logic [CW+COUNT_W-1:0] cnt_ext;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [DATA_W-1:0] out_largest_r;
  logic              out_empty_r;
  logic              out_full_r;

  // Entry storage
  slri_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared compare unit: read entry against the transaction's value
  assign cmp_gt = $signed(mem_rdata) > $signed(val_r);
  assign cmp_eq = (mem_rdata == val_r);

  assign full    = (cnt_r == CW'(DEPTH));
  assign k_dec   = k_r - 1'b1;
  assign k_inc   = k_r + 1'b1;
  assign w_inc   = w_r + 1'b1;
  assign cnt_dec = cnt_r - 1'b1;
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_INSERT: state_nxt = full ? ST_LG_RD : ST_INS_RD;
            OP_REMOVE: state_nxt = ST_REM_RD;
            OP_EVENS:  state_nxt = ST_EVN_RD;
            default:   state_nxt = ST_LG_RD;
          endcase
        end
      end
      ST_INS_RD:  state_nxt = (k_r == '0) ? ST_LG_RD : ST_INS_CMP;
      ST_INS_CMP: state_nxt = cmp_gt ? ST_INS_RD : ST_LG_RD;
      ST_REM_RD:  state_nxt = (k_r == cnt_r) ? ST_LG_RD : ST_REM_CMP;
      ST_REM_CMP: state_nxt = cmp_eq ? ST_SHF_RD : ST_REM_RD;
      ST_SHF_RD:  state_nxt = (k_inc >= cnt_r) ? ST_LG_RD : ST_SHF_WR;
      ST_SHF_WR:  state_nxt = ST_SHF_RD;
      ST_EVN_RD:  state_nxt = (k_r == cnt_r) ? ST_LG_RD : ST_EVN_CHK;
      ST_EVN_CHK: state_nxt = ST_EVN_RD;
      ST_LG_RD:   state_nxt = ST_DONE;
      ST_DONE:    state_nxt = load_out ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls and datapath register updates
  always_comb begin
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    w_nxt     = w_r;
    ok_nxt    = ok_r;
    mem_we    = 1'b0;
    mem_waddr = k_r[AW-1:0];
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = k_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ok_nxt = 1'b0;
          w_nxt  = '0;
          k_nxt  = (in_op == OP_INSERT) ? cnt_r : '0;
        end
      end
      ST_INS_RD: begin
        if (k_r == '0) begin
          // Value goes to the front
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          ok_nxt  = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_dec[AW-1:0];
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          // Move the larger entry up one slot
          mem_wdata = mem_rdata;
          k_nxt     = k_dec;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          ok_nxt  = 1'b1;
        end
      end
      ST_REM_RD: begin
        mem_re = (k_r != cnt_r);
      end
      ST_REM_CMP: begin
        if (!cmp_eq) begin
          k_nxt = k_inc;
        end
      end
      ST_SHF_RD: begin
        if (k_inc >= cnt_r) begin
          cnt_nxt = cnt_dec;
          ok_nxt  = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_inc[AW-1:0];
        end
      end
      ST_SHF_WR: begin
        // Close the gap one entry at a time
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        k_nxt     = k_inc;
      end
      ST_EVN_RD: begin
        if (k_r == cnt_r) begin
          ok_nxt  = (w_r != cnt_r);
          cnt_nxt = w_r;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_EVN_CHK: begin
        // Keep odd entries, compacting them downward
        if (mem_rdata[0]) begin
          mem_we    = 1'b1;
          mem_waddr = w_r[AW-1:0];
          mem_wdata = mem_rdata;
          w_nxt     = w_inc;
        end
        k_nxt = k_inc;
      end
      ST_LG_RD: begin
        mem_re    = (cnt_r != '0);
        mem_raddr = cnt_dec[AW-1:0];
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers and captured transaction
  always_ff @(posedge clk) begin
    k_r  <= k_nxt;
    w_r  <= w_nxt;
    ok_r <= ok_nxt;
    if (accept) begin
      op_r  <= in_op;
      val_r <= in_value;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok_r      <= ok_r;
      out_count_r   <= cnt_ext[COUNT_W-1:0];
      out_largest_r <= (cnt_r == '0) ? '0 : mem_rdata;
      out_empty_r   <= (cnt_r == '0);
      out_full_r    <= full;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_count    = out_count_r;
  assign out_largest  = out_largest_r;
  assign out_is_empty = out_empty_r;
  assign out_is_full  = out_full_r;

  // Count never passes the capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("stored count exceeds capacity");

  // Memory writes happen only in writing states
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_INS_RD || state_r == ST_INS_CMP ||
                state_r == ST_SHF_WR || state_r == ST_EVN_CHK))
    else $error("memory write outside a writing state");

  // Final insert step grows the list by exactly one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_CMP && !cmp_gt) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow count by one");

  // Compaction write pointer never runs ahead of the read pointer
  a_evn_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVN_RD || state_r == ST_EVN_CHK) |-> (w_r <= k_r))
    else $error("compaction pointer ahead of scan pointer");

  // Opcode held for the whole operation
  a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && $past(state_r) != ST_IDLE) |-> $stable(op_r))
    else $error("captured opcode changed mid-operation");

endmodule
